### rtl/core/tdcp_pkg.sv
// Shared types and character constants for the tagged decimal channel parser.
`default_nettype none

package tdcp_pkg;

	localparam int NUM_CH = 4;
	localparam int FRAME_BYTES_DEF = 20;
	localparam int VAL_W = 32;
	localparam int OFS_W = 16;

	typedef logic [7:0] byte_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic signed [OFS_W-1:0] offset_t;
	typedef logic [NUM_CH-1:0] ch_mask_t;

	localparam offset_t OFFSET_RESET = 16'sd126;

	// tag bases: channel k opens on OPEN_TAG_A + k, closes on CLOSE_TAG_A + k
	localparam byte_t OPEN_TAG_A  = 8'h41;
	localparam byte_t CLOSE_TAG_A = 8'h61;
	localparam byte_t CHAR_MINUS  = 8'h2D;
	localparam byte_t CHAR_ZERO   = 8'h30;

endpackage

`default_nettype wire

### rtl/core/tdcp_byte_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
`default_nettype none

interface tdcp_byte_if
	import tdcp_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/tdcp_result_if.sv
// Result channel: valid/ready handshake carrying the four held values and update mask.
`default_nettype none

interface tdcp_result_if
	import tdcp_pkg::*;
();
	logic     valid;
	logic     ready;
	value_t   value_a;
	value_t   value_b;
	value_t   value_c;
	value_t   value_d;
	ch_mask_t updated_mask;

	modport source (output valid, output value_a, output value_b, output value_c,
		output value_d, output updated_mask, input ready);
	modport sink (input valid, input value_a, input value_b, input value_c,
		input value_d, input updated_mask, output ready);
endinterface

`default_nettype wire

### rtl/core/tagged_decimal_channel_parser.sv
// Tagged decimal channel parser: frames of serial bytes into four held channel values.
//
// Usage:
//  - rx (sink): one serial byte per word. Bytes are grouped in frames of
//    FRAME_BYTES words. Tags A..D open channels, a..d close them; bytes in
//    between are parsed as signed decimal (value*10 + byte - '0').
//  - result (source): one word per frame, issued after the frame's last
//    byte, carrying all four held values and a mask of channels updated.
//  - cfg_we/cfg_wdata: value_offset, added to every parsed value. Write it
//    only while no frame is in progress.
// Timing: a byte is held in the input register; the frame state is updated
// as it leaves, and a frame's result word is registered as its last byte
// leaves. One byte per cycle is sustained unless a last byte stalls; the
// only loop is the per-channel accumulate (shift-add by ten) on frame state.
// Stall: the held values double as the result register, so while a result
// waits, bytes keep flowing until the next frame's last byte reaches the
// input register; that byte then waits, and rx.ready drops, until the
// pending result is taken.
// Reset: all frame state, held values and valids clear; offset returns
// to 126. No clearing pass.
`default_nettype none

module tagged_decimal_channel_parser
	import tdcp_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire offset_t cfg_wdata,
	tdcp_byte_if.sink    rx,
	tdcp_result_if.source result
);

	localparam int POS_W = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	// configuration
	offset_t offset_q;

	// input register stage
	logic  valid_s1;
	byte_t byte_s1;

	// frame state
	logic [POS_W-1:0] pos_q;
	ch_mask_t         opened_q, closed_q, has_q, neg_q;
	value_t           acc_q [NUM_CH];

	// held values, also the result register
	value_t   held_q [NUM_CH];
	ch_mask_t mask_q;
	logic     res_valid_q;

	// next-state values
	ch_mask_t opened_n, closed_n, has_n, neg_n;
	value_t   acc_n  [NUM_CH];
	value_t   held_n [NUM_CH];

	logic last_s1;
	logic advance;
	value_t offset_ext;

	assign last_s1    = (pos_q == POS_LAST);
	// the last byte of a frame may only leave once the result register is free
	assign advance    = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign rx.ready   = !valid_s1 || advance;
	assign offset_ext = VAL_W'(offset_q);

	// per-channel byte handling, all four channels in parallel
	always_comb begin
		byte_t  open_tag;
		byte_t  close_tag;
		value_t digit;
		value_t signed_v;
		opened_n = opened_q;
		closed_n = closed_q;
		has_n    = has_q;
		neg_n    = neg_q;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			open_tag  = OPEN_TAG_A + 8'(ch);
			close_tag = CLOSE_TAG_A + 8'(ch);
			digit     = value_t'({24'd0, byte_s1}) - value_t'({24'd0, CHAR_ZERO});
			acc_n[ch] = acc_q[ch];
			if (byte_s1 == open_tag) begin
				opened_n[ch] = 1'b1;
			end else if (byte_s1 == close_tag) begin
				closed_n[ch] = 1'b1;
			end else if (opened_q[ch] && !closed_q[ch]) begin
				if (last_s1) begin
					// still open at frame end: drop what was collected
					has_n[ch] = 1'b0;
					neg_n[ch] = 1'b0;
					acc_n[ch] = '0;
				end else if (!has_q[ch] && byte_s1 == CHAR_MINUS) begin
					has_n[ch] = 1'b1;
					neg_n[ch] = 1'b1;
				end else begin
					has_n[ch] = 1'b1;
					acc_n[ch] = (acc_q[ch] <<< 3) + (acc_q[ch] <<< 1) + digit;
				end
			end
			// only used on the last byte, where the accumulator is not stepped
			signed_v   = neg_q[ch] ? -acc_q[ch] : acc_q[ch];
			held_n[ch] = has_n[ch] ? signed_v + offset_ext : held_q[ch];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			opened_q    <= '0;
			closed_q    <= '0;
			has_q       <= '0;
			neg_q       <= '0;
			mask_q      <= '0;
			res_valid_q <= 1'b0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				acc_q[ch]  <= '0;
				held_q[ch] <= '0;
			end
		end else begin
			if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (advance) begin
				if (last_s1) begin
					// frame done: publish and start over
					pos_q       <= '0;
					opened_q    <= '0;
					closed_q    <= '0;
					has_q       <= '0;
					neg_q       <= '0;
					mask_q      <= has_n;
					res_valid_q <= 1'b1;
					for (int ch = 0; ch < NUM_CH; ch++) begin
						acc_q[ch]  <= '0;
						held_q[ch] <= held_n[ch];
					end
				end else begin
					pos_q    <= pos_q + 1'b1;
					opened_q <= opened_n;
					closed_q <= closed_n;
					has_q    <= has_n;
					neg_q    <= neg_n;
					for (int ch = 0; ch < NUM_CH; ch++) begin
						acc_q[ch] <= acc_n[ch];
					end
				end
			end
		end
	end

	assign result.valid        = res_valid_q;
	assign result.value_a      = held_q[0];
	assign result.value_b      = held_q[1];
	assign result.value_c      = held_q[2];
	assign result.value_d      = held_q[3];
	assign result.updated_mask = mask_q;

endmodule

`default_nettype wire

### tb/sv/tagged_decimal_channel_parser_tb.sv
// Self-checking testbench for the tagged decimal channel parser: directed frames, then random frames.
`default_nettype none

module tagged_decimal_channel_parser_tb
	import tdcp_pkg::*;
();

	localparam int FRAME_BYTES = FRAME_BYTES_DEF;
	localparam int NUM_ROWS = 6;
	localparam int NUM_PHASES = 6;
	// quiet cycles (no word moving on either side) before the run is declared hung
	localparam int WATCHDOG_CYCLES = 400;
	// cycles allowed after the last frame word for the block to go idle
	localparam int SETTLE_CYCLES = 6;
	// filler bytes: '.' pads short table rows, '~' in a row stands for byte 0x00,
	// space pads random frames
	localparam byte_t PAD_CHAR = 8'h2E;
	localparam byte_t NUL_MARK = 8'h7E;
	localparam byte_t FILL_CHAR = 8'h20;

	// one frame word as it should leave the block
	typedef struct {
		value_t   value [NUM_CH];
		ch_mask_t updated;
	} frame_report_t;

	// directed frame: text padded to a full frame, expected word typed in when known
	typedef struct {
		string         text;
		bit            typed;
		frame_report_t want;
	} frame_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    cfg_we;
	offset_t cfg_wdata;

	tdcp_byte_if   byte_ch ();
	tdcp_result_if res_ch ();

	tagged_decimal_channel_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx       (byte_ch),
		.result   (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Frame parser predictor: its own copy of the offset and frame state
	// ---------------------------------------------------------------
	value_t           offset_ext;
	int               frame_pos;
	bit               ch_open  [NUM_CH];
	bit               ch_shut  [NUM_CH];
	bit               ch_seen  [NUM_CH];
	bit               ch_minus [NUM_CH];
	logic [VAL_W-1:0] ch_acc   [NUM_CH];
	value_t           ch_held  [NUM_CH];

	frame_report_t pending_frames [$];
	int            mismatch_count = 0;
	bit            calm = 1'b0;      // set for the last phase: no idling on either side

	function automatic void clear_frame_state();
		frame_pos = 0;
		for (int k = 0; k < NUM_CH; k++) begin
			ch_open[k] = 1'b0;
			ch_shut[k] = 1'b0;
			ch_seen[k] = 1'b0;
			ch_minus[k] = 1'b0;
			ch_acc[k] = '0;
		end
	endfunction

	// Takes one accepted byte; returns 1 with the frame word on the frame's last byte.
	function automatic bit parse_frame_byte(input byte_t b, output frame_report_t rpt);
		bit               last;
		logic [VAL_W-1:0] v;
		last = frame_pos >= FRAME_BYTES - 1;
		rpt.updated = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			rpt.value[k] = '0;
			if (b == OPEN_TAG_A + byte_t'(k)) begin
				ch_open[k] = 1'b1;
			end else if (b == CLOSE_TAG_A + byte_t'(k)) begin
				ch_shut[k] = 1'b1;
			end else if (ch_open[k] && !ch_shut[k]) begin
				if (last) begin
					// still open when the frame ends: throw away what it collected
					ch_seen[k] = 1'b0;
					ch_minus[k] = 1'b0;
					ch_acc[k] = '0;
				end else if (!ch_seen[k] && b == CHAR_MINUS) begin
					ch_seen[k] = 1'b1;
					ch_minus[k] = 1'b1;
				end else begin
					// any other byte is a "digit", even out of range; wraps mod 2^32
					ch_seen[k] = 1'b1;
					ch_acc[k] = ch_acc[k] * 10 + (VAL_W'(b) - VAL_W'(CHAR_ZERO));
				end
			end
		end
		if (!last) begin
			frame_pos++;
			return 1'b0;
		end
		for (int k = 0; k < NUM_CH; k++) begin
			if (ch_seen[k]) begin
				v = ch_minus[k] ? -ch_acc[k] : ch_acc[k];
				ch_held[k] = v + offset_ext;
				rpt.updated[k] = 1'b1;
			end
			rpt.value[k] = ch_held[k];
		end
		clear_frame_state();
		return 1'b1;
	endfunction

	// Appends one expected frame word behind those already waiting.
	function automatic void queue_frame(input frame_report_t rpt);
		pending_frames.insert(pending_frames.size(), rpt);
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_result();
		frame_report_t want;
		value_t        got [NUM_CH];
		got = '{res_ch.value_a, res_ch.value_b, res_ch.value_c, res_ch.value_d};
		if (pending_frames.size() == 0) begin
			report_mismatch("result word with no frame pending");
			return;
		end
		want = pending_frames.pop_front();
		for (int k = 0; k < NUM_CH; k++) begin
			if (got[k] !== want.value[k])
				report_mismatch($sformatf("channel %0d value: got %0d, expected %0d",
					k, got[k], want.value[k]));
		end
		if (res_ch.updated_mask !== want.updated)
			report_mismatch($sformatf("updated_mask: got %b, expected %b",
				res_ch.updated_mask, want.updated));
	endtask

	// Result side: checks each word taken, then picks ready for the next edge.
	// Stalls come in bursts of random length.
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (!calm && stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 9);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run once no word has moved for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL tagged_decimal_channel_parser");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Sends one byte word, with an occasional idle burst first. On acceptance the
	// predictor runs; a table row's typed word replaces the predicted one.
	task automatic push_byte(input byte_t b, input bit use_row, input frame_report_t row_rpt);
		frame_report_t rpt;
		if (!calm && $urandom_range(0, 5) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.rx_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		if (parse_frame_byte(b, rpt)) begin
			if (use_row)
				queue_frame(row_rpt);
			else
				queue_frame(rpt);
		end
	endtask

	// Stops sending, waits for every frame word, then lets the pipeline empty.
	task automatic wait_for_idle();
		byte_ch.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(input offset_t ofs);
		cfg_we <= 1'b1;
		cfg_wdata <= ofs;
		@(posedge clk);
		cfg_we <= 1'b0;
		offset_ext = ofs;   // sign-extends
	endtask

	// Appends one byte to a frame under construction.
	function automatic void add_byte(ref byte_t frm[$], input byte_t b);
		frm.insert(frm.size(), b);
	endfunction

	// Random frame: mostly well-formed tagged fields with random digits, some
	// noise frames, some tag-heavy frames, some ending on a tag.
	function automatic void build_random_frame(ref byte_t frm[$]);
		int    kind;
		int    first;
		int    ch;
		string tag_rich;
		tag_rich = "AaBbCcDd-0123456789";
		frm.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat (FRAME_BYTES) add_byte(frm, byte_t'($urandom));
		end else if (kind == 1) begin
			repeat (FRAME_BYTES)
				add_byte(frm, byte_t'(tag_rich[$urandom_range(0, tag_rich.len() - 1)]));
		end else begin
			first = $urandom_range(0, NUM_CH - 1);
			for (int i = 0; i < NUM_CH; i++) begin
				ch = (first + i) % NUM_CH;
				if ($urandom_range(0, 1) == 0)
					add_byte(frm, ($urandom_range(0, 5) == 0) ? byte_t'($urandom) : FILL_CHAR);
				if ($urandom_range(0, 3) != 0) begin
					add_byte(frm, OPEN_TAG_A + byte_t'(ch));
					if ($urandom_range(0, 3) == 0)
						add_byte(frm, CHAR_MINUS);
					// now and then a long run to wrap the accumulator
					repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4))
						add_byte(frm, CHAR_ZERO + byte_t'($urandom_range(0, 9)));
					if ($urandom_range(0, 7) == 0)
						add_byte(frm, byte_t'($urandom));
					// sometimes left open: dropped at frame end
					if ($urandom_range(0, 7) != 0)
						add_byte(frm, CLOSE_TAG_A + byte_t'(ch));
				end
			end
			while (frm.size() < FRAME_BYTES) add_byte(frm, FILL_CHAR);
			while (frm.size() > FRAME_BYTES) void'(frm.pop_back());
			if (kind == 9)
				frm[FRAME_BYTES - 1] = (($urandom_range(0, 1) == 0) ? OPEN_TAG_A : CLOSE_TAG_A)
					+ byte_t'($urandom_range(0, NUM_CH - 1));
		end
	endfunction

	initial begin
		frame_row_t    frame_rows [NUM_ROWS];
		offset_t       phase_offsets [NUM_PHASES];
		frame_report_t no_row;
		byte_t         frm [$];
		byte_t         c;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = '0;

		offset_ext = OFFSET_RESET;
		clear_frame_state();
		for (int k = 0; k < NUM_CH; k++) ch_held[k] = '0;
		no_row = '{'{0, 0, 0, 0}, 4'h0};

		// Directed frames, all at the reset offset of 126.
		// nothing tagged, zero bytes: nothing updated, held values still zero
		frame_rows[0] = '{"~~~~", 1'b1, '{'{0, 0, 0, 0}, 4'h0}};
		// plain digit, lone minus, negative number, zero
		frame_rows[1] = '{"A5aB-bC-12cD0d", 1'b1, '{'{131, 126, 114, 126}, 4'hF}};
		// close before open, tag repeated after close, empty field, later minus as digit
		frame_rows[2] = '{"aA7bB9bBx2Cc-D-5-d", 1'b0, no_row};
		// wrapping digit run, zero byte and 0xFF as digits, C still open at frame end
		frame_rows[3] = '{"A9999999999~aB\377bC", 1'b0, no_row};
		// last byte is the closing tag: field kept
		frame_rows[4] = '{"D123456789012345678d", 1'b0, no_row};
		// last byte is B's opening tag (kept), A still open (dropped)
		frame_rows[5] = '{"AB12...............B", 1'b0, no_row};

		phase_offsets = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
			offset_t'($urandom), offset_t'($urandom)};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				c = (i < frame_rows[r].text.len()) ? byte_t'(frame_rows[r].text[i]) : PAD_CHAR;
				if (c == NUL_MARK)
					c = 8'h00;
				push_byte(c, frame_rows[r].typed, frame_rows[r].want);
			end
		end

		// Random phases, each at a new offset written while the block is idle.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_for_idle();
			if (ph == NUM_PHASES - 1)
				calm = 1'b1;
			write_offset(phase_offsets[ph]);
			for (int f = 0; f < 4 + ph % 2; f++) begin
				build_random_frame(frm);
				foreach (frm[i])
					push_byte(frm[i], 1'b0, no_row);
			end
		end

		wait_for_idle();
		if (mismatch_count == 0)
			$display("PASS tagged_decimal_channel_parser");
		else
			$display("FAIL tagged_decimal_channel_parser");
		$finish;
	end

endmodule

`default_nettype wire

### tagged_decimal_channel_parser.f
rtl/core/tdcp_pkg.sv
rtl/core/tdcp_byte_if.sv
rtl/core/tdcp_result_if.sv
rtl/core/tagged_decimal_channel_parser.sv
tb/sv/tagged_decimal_channel_parser_tb.sv
